// ----- src/grid_ray_collision_check_unit_defines.svh -----
// ----------------------------------------------------------------------------
// grid_ray_collision_check_unit_defines.svh
// Assertion macros shared by the line-of-sight check RTL.
// ----------------------------------------------------------------------------
`ifndef GRID_RAY_COLLISION_CHECK_UNIT_DEFINES_SVH
`define GRID_RAY_COLLISION_CHECK_UNIT_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define GRCC_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define GRCC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/grcc_pkg.sv -----
// ----------------------------------------------------------------------------
// grcc_pkg
// Constants and types of the occupancy-grid line-of-sight check.
// ----------------------------------------------------------------------------
package grcc_pkg;

  localparam int GRID_SIDE = 64;
  localparam int CW        = 6;                         // coordinate width
  localparam int FRAC_BITS = 24;
  localparam int SQW       = 2 * CW;                    // one squared delta
  localparam int SW        = 2 * CW + 1;                // dx^2 + dy^2
  localparam int NW        = CW + 1;                    // sample count
  localparam int DIVW      = SQW + 2 * FRAC_BITS + 2;   // d^2 * 2^(2F+2)
  localparam int QW        = 2 * FRAC_BITS + 4;         // sqrt radicand
  localparam int RTW       = QW / 2;                    // sqrt root
  localparam int RMW       = RTW + 2;                   // sqrt remainder
  localparam int MW        = FRAC_BITS + 1;             // unit magnitude
  localparam int PW        = FRAC_BITS + CW + 4;        // sample position
  localparam int DCW       = $clog2(DIVW);
  localparam int SCW       = $clog2(RTW);

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WR_RD,
    ST_WR_WB,
    ST_Q_N,
    ST_Q_DIV,
    ST_Q_SQRT,
    ST_Q_UNIT,
    ST_Q_RD,
    ST_Q_CHK,
    ST_DONE
  } state_t;

endpackage

// ----- src/grid_ray_collision_check_unit.sv -----
// ----------------------------------------------------------------------------
// grid_ray_collision_check_unit
// Occupancy grid with cell writes and straight-segment collision queries.
// ----------------------------------------------------------------------------
//  channel | signals                                  | moves
//  --------+------------------------------------------+---------------------
//  in      | in_valid/in_ready, opcode, cell_*, ...    | one write or query
//  out     | out_valid/out_ready, collision, is_query  | one answer per item
//
//  Write: read row, write row back, result.
//  Query: counts the samples, n = ceil(|to - from|), then runs the
//  1-bit/cycle divider and 2-bit/cycle square root per axis, then does
//  one grid read per sampled cell.
//  Reset: a clearing pass wipes the grid, one row per cycle;
//  in_ready stays low meanwhile.
//  Output register: a new item is taken while an answer waits; the block
//  stalls at its end until the output register is free.
// ----------------------------------------------------------------------------
`include "grid_ray_collision_check_unit_defines.svh"

module grid_ray_collision_check_unit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 opcode,
  input  logic [grcc_pkg::CW-1:0] cell_x,
  input  logic [grcc_pkg::CW-1:0] cell_y,
  input  logic                 cell_occupied,
  input  logic [grcc_pkg::CW-1:0] from_x,
  input  logic [grcc_pkg::CW-1:0] from_y,
  input  logic [grcc_pkg::CW-1:0] to_x,
  input  logic [grcc_pkg::CW-1:0] to_y,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 collision,
  output logic                 is_query_answer
);
  import grcc_pkg::*;

  // Grid memory: one row (all y) per word, row index = x.
  logic [GRID_SIDE-1:0] grid_mem [GRID_SIDE];
  logic [GRID_SIDE-1:0] rd_row;
  logic                 mem_re, mem_we;
  logic [CW-1:0]        mem_addr;
  logic [GRID_SIDE-1:0] mem_wdata;

  state_t state, state_next;

  logic [CW-1:0] clr_row;
  logic [CW-1:0] wr_x, wr_y;
  logic          wr_occ;
  logic [CW-1:0] fx, fy, tx, ty;
  logic          is_q;
  logic          res_coll;

  // Query setup
  logic [CW-1:0]  ady;             // |dy|, for the second axis
  logic           negx, negy;
  logic [SW-1:0]  s_sum;
  logic [NW-1:0]  n_cnt;
  logic           axis;            // 0: x, 1: y

  // Restoring divider: d^2 * 2^(2F+2) / S
  logic [DIVW-1:0] dreg, dreg_step;
  logic [SW-1:0]   drem, drem_step;
  logic [SW:0]     drem_sh;
  logic [DCW-1:0]  div_cnt;

  // Bit-pair square root
  logic [QW-1:0]  sq_val;
  logic [RMW-1:0] sq_rem, sq_rem_step, sq_rem_t, sq_trial;
  logic [RTW-1:0] sq_root, sq_root_step;
  logic [SCW-1:0] sq_cnt;
  logic [RTW:0]   root_inc;
  logic [MW-1:0]  m_new;

  logic [MW-1:0]  ux_mag, uy_mag;
  logic signed [PW-1:0] px, py, ux_s, uy_s;
  logic [NW-1:0]  cnt;
  logic [CW-1:0]  chk_y;
  logic [CW-1:0]  rd_x, rd_y;

  // Input absolute deltas, combinational on the ports
  logic [CW-1:0] in_adx, in_ady;
  logic [SQW-1:0] in_sqx, in_sqy;
  logic [SQW-1:0] sqy;

  logic accept, out_load;
  logic [2*NW-1:0] n_sq;

  function automatic logic [CW-1:0] clamp_cell(input logic signed [PW-1:0] p);
    logic [CW-1:0] r;
    if (p[PW-1]) begin
      r = '0;
    end else if (|p[PW-2:FRAC_BITS+CW]) begin
      r = CW'(GRID_SIDE - 1);
    end else begin
      r = p[FRAC_BITS+CW-1:FRAC_BITS];
    end
    return r;
  endfunction

  assign accept   = in_valid && in_ready;
  assign in_ready = (state == ST_IDLE);
  assign out_load = (state == ST_DONE) && (!out_valid || out_ready);

  assign in_adx = (to_x >= from_x) ? (to_x - from_x) : (from_x - to_x);
  assign in_ady = (to_y >= from_y) ? (to_y - from_y) : (from_y - to_y);
  assign in_sqx = in_adx * in_adx;
  assign in_sqy = in_ady * in_ady;
  assign sqy    = ady * ady;
  assign n_sq   = n_cnt * n_cnt;

  // Divider step
  assign drem_sh   = {drem, dreg[DIVW-1]};
  always_comb begin
    if (drem_sh >= {1'b0, s_sum}) begin
      drem_step = SW'(drem_sh - {1'b0, s_sum});
      dreg_step = {dreg[DIVW-2:0], 1'b1};
    end else begin
      drem_step = drem_sh[SW-1:0];
      dreg_step = {dreg[DIVW-2:0], 1'b0};
    end
  end

  // Square root step
  assign sq_rem_t = {sq_rem[RMW-3:0], sq_val[QW-1:QW-2]};
  assign sq_trial = {sq_root, 2'b01};
  always_comb begin
    if (sq_rem_t >= sq_trial) begin
      sq_rem_step  = sq_rem_t - sq_trial;
      sq_root_step = {sq_root[RTW-2:0], 1'b1};
    end else begin
      sq_rem_step  = sq_rem_t;
      sq_root_step = {sq_root[RTW-2:0], 1'b0};
    end
  end
  // Round to nearest: largest m with (2m-1)^2 <= q is (isqrt(q)+1)/2.
  assign root_inc = {1'b0, sq_root_step} + (RTW+1)'(1);
  assign m_new    = root_inc[MW:1];

  assign ux_s = negx ? -$signed({{(PW-MW){1'b0}}, ux_mag})
                     :  $signed({{(PW-MW){1'b0}}, ux_mag});
  assign uy_s = negy ? -$signed({{(PW-MW){1'b0}}, uy_mag})
                     :  $signed({{(PW-MW){1'b0}}, uy_mag});

  // Which cell to read: samples first, then start cell, then end cell.
  always_comb begin
    if (cnt < n_cnt) begin
      rd_x = clamp_cell(px);
      rd_y = clamp_cell(py);
    end else if (cnt == n_cnt) begin
      rd_x = fx;
      rd_y = fy;
    end else begin
      rd_x = tx;
      rd_y = ty;
    end
  end

  // Next state and memory controls
  always_comb begin
    state_next = state;
    mem_re     = 1'b0;
    mem_we     = 1'b0;
    mem_addr   = rd_x;
    mem_wdata  = '0;
    case (state)
      ST_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = clr_row;
        if (clr_row == CW'(GRID_SIDE - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          if (opcode == OP_WRITE) begin
            state_next = ST_WR_RD;
          end else if (from_x == to_x && from_y == to_y) begin
            state_next = ST_DONE;
          end else begin
            state_next = ST_Q_N;
          end
        end
      end
      ST_WR_RD: begin
        mem_re     = 1'b1;
        mem_addr   = wr_x;
        state_next = ST_WR_WB;
      end
      ST_WR_WB: begin
        mem_we            = 1'b1;
        mem_addr          = wr_x;
        mem_wdata         = rd_row;
        mem_wdata[wr_y]   = wr_occ;
        state_next        = ST_DONE;
      end
      ST_Q_N: begin
        if (n_sq >= (2*NW)'(s_sum)) state_next = ST_Q_DIV;
      end
      ST_Q_DIV: begin
        if (div_cnt == DCW'(DIVW - 1)) state_next = ST_Q_SQRT;
      end
      ST_Q_SQRT: begin
        if (sq_cnt == SCW'(RTW - 1)) state_next = axis ? ST_Q_UNIT : ST_Q_DIV;
      end
      ST_Q_UNIT: begin
        state_next = ST_Q_RD;
      end
      ST_Q_RD: begin
        mem_re     = 1'b1;
        mem_addr   = rd_x;
        state_next = ST_Q_CHK;
      end
      ST_Q_CHK: begin
        if (rd_row[chk_y] || cnt == n_cnt + NW'(1)) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_Q_RD;
        end
      end
      ST_DONE: begin
        if (out_load) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) grid_mem[mem_addr] <= mem_wdata;
    if (mem_re) rd_row <= grid_mem[mem_addr];
  end

  // Clearing-pass row counter
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_row <= '0;
    end else if (state == ST_CLEAR) begin
      clr_row <= clr_row + CW'(1);
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          wr_x     <= cell_x;
          wr_y     <= cell_y;
          wr_occ   <= cell_occupied;
          fx       <= from_x;
          fy       <= from_y;
          tx       <= to_x;
          ty       <= to_y;
          is_q     <= (opcode == OP_QUERY);
          res_coll <= (opcode == OP_QUERY);   // equal cells answer 1
          ady      <= in_ady;
          negx     <= (to_x < from_x);
          negy     <= (to_y < from_y);
          s_sum    <= SW'(in_sqx) + SW'(in_sqy);
          n_cnt    <= '0;
          axis     <= 1'b0;
          div_cnt  <= '0;
          drem     <= '0;
          dreg     <= {in_sqx, {(DIVW-SQW){1'b0}}};
        end
      end
      ST_WR_WB: begin
        res_coll <= 1'b0;
      end
      ST_Q_N: begin
        if (n_sq < (2*NW)'(s_sum)) n_cnt <= n_cnt + NW'(1);
      end
      ST_Q_DIV: begin
        drem    <= drem_step;
        dreg    <= dreg_step;
        div_cnt <= div_cnt + DCW'(1);
        if (div_cnt == DCW'(DIVW - 1)) begin
          sq_val  <= dreg_step[QW-1:0];
          sq_rem  <= '0;
          sq_root <= '0;
          sq_cnt  <= '0;
        end
      end
      ST_Q_SQRT: begin
        sq_val  <= {sq_val[QW-3:0], 2'b00};
        sq_rem  <= sq_rem_step;
        sq_root <= sq_root_step;
        sq_cnt  <= sq_cnt + SCW'(1);
        if (sq_cnt == SCW'(RTW - 1)) begin
          if (axis) begin
            uy_mag <= m_new;
          end else begin
            ux_mag  <= m_new;
            axis    <= 1'b1;
            div_cnt <= '0;
            drem    <= '0;
            dreg    <= {sqy, {(DIVW-SQW){1'b0}}};
          end
        end
      end
      ST_Q_UNIT: begin
        // start + half cell toward the direction of travel
        px  <= $signed({{(PW-CW-FRAC_BITS){1'b0}}, fx, {FRAC_BITS{1'b0}}})
               + (negx ? -(PW'(1) <<< (FRAC_BITS-1)) : (PW'(1) <<< (FRAC_BITS-1)));
        py  <= $signed({{(PW-CW-FRAC_BITS){1'b0}}, fy, {FRAC_BITS{1'b0}}})
               + (negy ? -(PW'(1) <<< (FRAC_BITS-1)) : (PW'(1) <<< (FRAC_BITS-1)));
        cnt <= '0;
      end
      ST_Q_RD: begin
        chk_y <= rd_y;
      end
      ST_Q_CHK: begin
        if (rd_row[chk_y]) begin
          res_coll <= 1'b1;
        end else if (cnt == n_cnt + NW'(1)) begin
          res_coll <= 1'b0;
        end else begin
          if (cnt < n_cnt) begin
            px <= px + ux_s;
            py <= py + uy_s;
          end
          cnt <= cnt + NW'(1);
        end
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      collision       <= res_coll;
      is_query_answer <= is_q;
    end
  end

  // Checks
  `GRCC_ASSERT_IMPL(a_no_take_in_clear, clk, rst, state == ST_CLEAR, !in_ready, "item taken during clearing pass")
  `GRCC_ASSERT_IMPL(a_write_ack_clean, clk, rst, out_valid && !is_query_answer, !collision, "write acknowledge reports a collision")
  `GRCC_ASSERT_IMPL(a_sample_bound, clk, rst, state == ST_Q_RD, cnt <= n_cnt + NW'(1), "sample index past end")
  `GRCC_ASSERT_NEXT(a_done_loads, clk, rst, out_load, out_valid, "finished answer not presented")

endmodule
